// ----- rtl/core/pfhd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pfhd_pkg
// Shared constants and types of the page frame buffer line drawing unit.
// ----------------------------------------------------------------------------
package pfhd_pkg;

  // screen geometry
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;

  localparam int PAGE_ROWS    = 8;
  localparam int PAGE_COUNT   = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int BUFFER_BYTES = SCREEN_WIDTH * PAGE_COUNT;

  localparam int ADDR_W = $clog2(BUFFER_BYTES);
  localparam int COL_W  = $clog2(SCREEN_WIDTH + 1);

  // operation codes
  localparam logic [1:0] OP_DRAW  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // colour codes that change pixels
  localparam logic [7:0] COLOUR_CLEAR = 8'd0;
  localparam logic [7:0] COLOUR_SET   = 8'd1;

  // one request as taken from the input channel
  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] start_x;
    logic signed [15:0] row_y;
    logic [7:0]         span_width;
    logic [7:0]         colour;
    logic [9:0]         read_index;
  } item_t;

  // buffer memory access
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // finished result towards the output register
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/core/pfhd_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pfhd_ram
// Generic simple dual port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pfhd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/core/pfhd_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pfhd_ctrl
// Sequencer: clips a line, walks its columns with read-modify-write,
// sweeps the buffer for clear and after reset, and serves byte reads.
// ----------------------------------------------------------------------------
module pfhd_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire pfhd_pkg::item_t           item_i,
  output pfhd_pkg::mem_req_t             mem_o,
  input  wire logic [7:0]                rdata_i,
  output pfhd_pkg::res_t                 res_o,
  input  wire logic                      res_take_i
);
  import pfhd_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_DRAW  = 3'd2;
  localparam logic [2:0] ST_CLEAR = 3'd3;
  localparam logic [2:0] ST_RDATA = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam logic signed [16:0] WIDTH_S   = 17'(SCREEN_WIDTH);
  localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(BUFFER_BYTES - 1);

  logic [2:0]        state_q, state_d;
  item_t             item_q;
  logic              owe_q, owe_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [COL_W-1:0]  end_q, end_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [7:0]        bit_q, bit_d;
  logic              set_q, set_d;
  logic              pend_q, pend_d;
  logic [ADDR_W-1:0] pend_addr_q, pend_addr_d;
  logic [7:0]        res_q, res_d;

  logic                accept;
  logic signed [16:0]  x0_s;
  logic signed [16:0]  x1_s;
  logic                row_ok;
  logic                colour_ok;
  logic                skip;
  logic                in_range;
  logic                col_more;
  logic [ADDR_W-1:0]   col_addr;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  // clipping of the line against the screen
  assign x0_s      = {item_q.start_x[15], item_q.start_x};
  assign x1_s      = x0_s + $signed({9'd0, item_q.span_width});
  assign row_ok    = !item_q.row_y[15] && (item_q.row_y[14:0] < 15'(SCREEN_HEIGHT));
  assign colour_ok = (item_q.colour == COLOUR_SET) || (item_q.colour == COLOUR_CLEAR);
  assign skip      = !row_ok || !colour_ok || (x1_s <= 17'sd0) || (x0_s >= WIDTH_S);
  assign in_range  = {6'd0, item_q.read_index} < 16'(BUFFER_BYTES);

  // column walk
  assign col_more = (col_q < end_q);
  assign col_addr = base_q + ADDR_W'(col_q);

  // next state and memory access
  always_comb begin
    state_d     = state_q;
    owe_d       = owe_q;
    clr_d       = clr_q;
    col_d       = col_q;
    end_d       = end_q;
    base_d      = base_q;
    bit_d       = bit_q;
    set_d       = set_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    res_d       = res_q;
    mem_o.we    = 1'b0;
    mem_o.waddr = pend_addr_q;
    mem_o.wdata = 8'd0;
    mem_o.raddr = col_addr;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        res_d = 8'd0;
        case (item_q.op)
          OP_DRAW: begin
            if (skip) begin
              state_d = ST_DONE;
            end else begin
              state_d = ST_DRAW;
              col_d   = x0_s[16] ? '0 : COL_W'(x0_s);
              end_d   = (x1_s > WIDTH_S) ? COL_W'(SCREEN_WIDTH) : COL_W'(x1_s);
              base_d  = ADDR_W'(int'(item_q.row_y[14:3]) * SCREEN_WIDTH);
              bit_d   = 8'd1 << item_q.row_y[2:0];
              set_d   = (item_q.colour == COLOUR_SET);
              pend_d  = 1'b0;
            end
          end
          OP_CLEAR: begin
            state_d = ST_CLEAR;
            clr_d   = '0;
            owe_d   = 1'b1;
          end
          OP_READ: begin
            state_d     = ST_RDATA;
            mem_o.raddr = ADDR_W'(item_q.read_index);
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_DRAW: begin
        // write back the byte read in the previous cycle
        if (pend_q) begin
          mem_o.we    = 1'b1;
          mem_o.wdata = set_q ? (rdata_i | bit_q) : (rdata_i & ~bit_q);
        end
        // fetch the next column
        if (col_more) begin
          col_d       = col_q + 1'b1;
          pend_d      = 1'b1;
          pend_addr_d = col_addr;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_CLEAR: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = clr_q;
        clr_d       = clr_q + 1'b1;
        if (clr_q == LAST_ADDR) begin
          state_d = owe_q ? ST_DONE : ST_IDLE;
          owe_d   = 1'b0;
        end
      end
      ST_RDATA: begin
        res_d   = in_range ? rdata_i : 8'd0;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o.valid = (state_q == ST_DONE);
  assign res_o.data  = res_q;

  // control registers, reset starts the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      owe_q   <= 1'b0;
      clr_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      owe_q   <= owe_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
    col_q       <= col_d;
    end_q       <= end_d;
    base_q      <= base_d;
    bit_q       <= bit_d;
    set_q       <= set_d;
    pend_addr_q <= pend_addr_d;
    res_q       <= res_d;
  end

  // no buffer write outside a line walk or a sweep
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_DONE) |-> !mem_o.we)
    else $error("buffer written while idle");

  // write-back and fetch never hit the same byte
  a_rmw_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAW && pend_q && col_more) |-> (mem_o.waddr != mem_o.raddr))
    else $error("read-modify-write overlap");

  // column pointer stays inside the clipped span
  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAW) |-> (col_q <= end_q && end_q <= COL_W'(SCREEN_WIDTH)))
    else $error("column pointer past span end");

  // a pending write-back only lives inside a line walk
  a_pend_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == ST_DRAW))
    else $error("write-back pending outside line walk");

endmodule
`default_nettype wire

// ----- rtl/core/page_framebuffer_hline_draw_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// page_framebuffer_hline_draw_unit
// Monochrome frame buffer in 8-row pages with horizontal line drawing,
// buffer clear and byte read-back.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   op, start_x, row_y, span_width,
//                                            colour, read_index
//  out      output     out_valid / out_stall read_data
//
//  A line is drawn column by column: one read-modify-write per column
//  through the buffer RAM, fetch and write-back overlapped.
//  A clear sweeps the RAM one byte a cycle, and after reset the same sweep
//  of all BUFFER_BYTES (1024) bytes runs with in_stall high. A new request
//  is taken while a result waits in the output register; a stalled output
//  holds the next result back in the sequencer.
// ----------------------------------------------------------------------------
module page_framebuffer_hline_draw_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [15:0] start_x_i,
  input  wire logic [15:0] row_y_i,
  input  wire logic [7:0]  span_width_i,
  input  wire logic [7:0]  colour_i,
  input  wire logic [9:0]  read_index_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       read_data_o
);
  import pfhd_pkg::*;

  item_t      item;
  mem_req_t   mem_req;
  res_t       res;
  logic [7:0] rdata;
  logic       out_free;
  logic       res_take;
  logic       out_valid_q;
  logic [7:0] read_data_q;

  // gather the request fields
  assign item.op         = op_i;
  assign item.start_x    = $signed(start_x_i);
  assign item.row_y      = $signed(row_y_i);
  assign item.span_width = span_width_i;
  assign item.colour     = colour_i;
  assign item.read_index = read_index_i;

  // sequencer
  pfhd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (item),
    .mem_o      (mem_req),
    .rdata_i    (rdata),
    .res_o      (res),
    .res_take_i (res_take)
  );

  // frame buffer memory
  pfhd_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  // output register
  assign out_free = !out_valid_q || !out_stall_i;
  assign res_take = res.valid && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      read_data_q <= res.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

endmodule
`default_nettype wire
